FILE: design/drive_profile_power_state_machine_macros.svh
// Assertion macros used by the drive power state machine RTL.
`ifndef DRIVE_PROFILE_POWER_STATE_MACHINE_MACROS_SVH
`define DRIVE_PROFILE_POWER_STATE_MACHINE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define DPPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clock edge, during reset too.
`define DPPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/dpps_pkg.sv
// Types, command encodings and status patterns of the drive power state machine.
`default_nettype none

package dpps_pkg;

  // Drive power states
  typedef enum logic [2:0] {
    ST_NOT_READY   = 3'd0,
    ST_SWITCH_DIS  = 3'd1,
    ST_READY       = 3'd2,
    ST_SWITCHED_ON = 3'd3,
    ST_OP_ENABLED  = 3'd4,
    ST_QUICK_STOP  = 3'd5,
    ST_FAULT_REACT = 3'd6,
    ST_FAULT       = 3'd7
  } power_state_e;

  // Control word command masks and values
  localparam logic [15:0] MASK_SHUTDOWN   = 16'h0087;
  localparam logic [15:0] MASK_SWITCH     = 16'h008F;
  localparam logic [15:0] MASK_DISABLE_V  = 16'h0082;
  localparam logic [15:0] MASK_QSTOP      = 16'h0086;
  localparam logic [15:0] CMD_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CMD_SWITCH_ON   = 16'h0007;
  localparam logic [15:0] CMD_DISABLE_OP  = 16'h0007;
  localparam logic [15:0] CMD_ENABLE_OP   = 16'h000F;
  localparam logic [15:0] CMD_DISABLE_V   = 16'h0000;
  localparam logic [15:0] CMD_QSTOP       = 16'h0002;
  localparam int unsigned FAULT_RESET_BIT = 7;

  // Status word flag positions
  localparam int unsigned SW_VOLTAGE_BIT = 4;
  localparam int unsigned SW_WARNING_BIT = 9;
  localparam int unsigned SW_TARGET_BIT  = 10;
  localparam int unsigned SW_STALL_BIT   = 12;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 88;

  // Result of one state update
  typedef struct packed {
    power_state_e next_state;
    logic [1:0]   trans_inc;
    logic         fault_inc;
  } step_t;

  // Base status pattern of each state
  function automatic logic [15:0] base_pattern(power_state_e s);
    logic [15:0] p;
    case (s)
      ST_NOT_READY:   p = 16'h0000;
      ST_SWITCH_DIS:  p = 16'h0040;
      ST_READY:       p = 16'h0021;
      ST_SWITCHED_ON: p = 16'h0023;
      ST_OP_ENABLED:  p = 16'h0027;
      ST_QUICK_STOP:  p = 16'h0007;
      ST_FAULT_REACT: p = 16'h000F;
      ST_FAULT:       p = 16'h0008;
      default:        p = 16'h0000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: design/dpps_next_state.sv
// Next-state and counter increment logic of the drive power state machine.
`default_nettype none

module dpps_next_state (
  input  dpps_pkg::power_state_e state_i,
  input  logic [15:0]            cmd_word_i,
  input  logic                   fault_present_i,
  output dpps_pkg::step_t        step_o
);
  import dpps_pkg::*;

  logic         is_shutdown, is_switch_on, is_disable_op, is_enable_op;
  logic         is_disable_v, is_qstop, is_fault_reset;
  logic         fault_entry;
  power_state_e nxt;

  // Command decode
  assign is_shutdown    = (cmd_word_i & MASK_SHUTDOWN) == CMD_SHUTDOWN;
  assign is_switch_on   = (cmd_word_i & MASK_SWITCH) == CMD_SWITCH_ON;
  assign is_disable_op  = (cmd_word_i & MASK_SWITCH) == CMD_DISABLE_OP;
  assign is_enable_op   = (cmd_word_i & MASK_SWITCH) == CMD_ENABLE_OP;
  assign is_disable_v   = (cmd_word_i & MASK_DISABLE_V) == CMD_DISABLE_V;
  assign is_qstop       = (cmd_word_i & MASK_QSTOP) == CMD_QSTOP;
  assign is_fault_reset = cmd_word_i[FAULT_RESET_BIT];

  // New fault outside the fault states jumps straight to fault
  assign fault_entry = fault_present_i && (state_i != ST_FAULT) &&
                       (state_i != ST_FAULT_REACT);

  // State graph
  always_comb begin
    nxt = state_i;
    case (state_i)
      ST_NOT_READY:   nxt = ST_SWITCH_DIS;
      ST_SWITCH_DIS:  if (is_shutdown) nxt = ST_READY;
      ST_READY: begin
        if (is_switch_on)      nxt = ST_SWITCHED_ON;
        else if (is_disable_v) nxt = ST_SWITCH_DIS;
      end
      ST_SWITCHED_ON: begin
        if (is_enable_op)      nxt = ST_OP_ENABLED;
        else if (is_shutdown)  nxt = ST_READY;
        else if (is_disable_v) nxt = ST_SWITCH_DIS;
      end
      ST_OP_ENABLED: begin
        if (is_disable_op)     nxt = ST_SWITCHED_ON;
        else if (is_shutdown)  nxt = ST_READY;
        else if (is_disable_v) nxt = ST_SWITCH_DIS;
        else if (is_qstop)     nxt = ST_QUICK_STOP;
      end
      ST_QUICK_STOP:  if (is_disable_v) nxt = ST_SWITCH_DIS;
      ST_FAULT_REACT: nxt = ST_FAULT;
      ST_FAULT:       if (is_fault_reset && !fault_present_i) nxt = ST_SWITCH_DIS;
      default:        nxt = state_i;
    endcase
  end

  // Fault entry counts two transitions: into fault reaction, then into fault
  always_comb begin
    if (fault_entry) begin
      step_o.next_state = ST_FAULT;
      step_o.trans_inc  = 2'd2;
      step_o.fault_inc  = 1'b1;
    end else begin
      step_o.next_state = nxt;
      step_o.trans_inc  = (nxt != state_i) ? 2'd1 : 2'd0;
      step_o.fault_inc  = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/dpps_status.sv
// Status word and derived flags for a drive power state.
`default_nettype none

module dpps_status (
  input  dpps_pkg::power_state_e state_i,
  input  logic                   warning_flag_i,
  input  logic                   target_reached_flag_i,
  input  logic                   stall_flag_i,
  output logic [15:0]            stat_word_o,
  output logic                   op_enabled_o,
  output logic                   faulted_o
);
  import dpps_pkg::*;

  logic voltage_on;

  // Voltage is applied from ready to switch on through quick stop
  assign voltage_on = (state_i == ST_READY) || (state_i == ST_SWITCHED_ON) ||
                      (state_i == ST_OP_ENABLED) || (state_i == ST_QUICK_STOP);

  // Base pattern plus flag bits
  always_comb begin
    stat_word_o                 = base_pattern(state_i);
    stat_word_o[SW_VOLTAGE_BIT] = voltage_on;
    stat_word_o[SW_WARNING_BIT] = warning_flag_i;
    stat_word_o[SW_TARGET_BIT]  = target_reached_flag_i;
    stat_word_o[SW_STALL_BIT]   = stall_flag_i;
  end

  assign op_enabled_o = state_i == ST_OP_ENABLED;
  assign faulted_o    = (state_i == ST_FAULT) || (state_i == ST_FAULT_REACT);

endmodule

`default_nettype wire

FILE: design/drive_profile_power_state_machine.sv
// An accepted transaction sits in the input register, moves into the result register
// as the state is updated, and leaves from there once the receiver takes it.
// Throughput: one transaction per cycle while the output is free; the next state is
// computed combinationally from the state register; both registers advance together when the output is free.
// Reset (rst_ni low, asynchronous): state goes to not ready to switch on, both
// counters clear, and no transaction is held in either register.
`default_nettype none

module drive_profile_power_state_machine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // cmd_word[15:0], fault_present[16], warning_flag[17],
  // target_reached_flag[18], stall_flag[19], zero pad [23:20]
  input  logic [dpps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // drive_state[2:0], stat_word[18:3], op_enabled[19], faulted[20],
  // transition_total[52:21], fault_total[84:53], zero pad [87:85]
  output logic [dpps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);
  import dpps_pkg::*;
  `include "drive_profile_power_state_machine_macros.svh"

  logic                  in_valid_q;
  logic [IN_TDATA_W-1:0] in_data_q;
  power_state_e          state_q;
  logic [31:0]           trans_cnt_q, trans_cnt_d;
  logic [31:0]           fault_cnt_q, fault_cnt_d;
  logic                  out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                  advance, proc, in_take;
  step_t                 step;
  logic [15:0]           stat_word;
  logic                  op_enabled, faulted;

  // Pipeline flow: the output register frees up or is being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // State update
  dpps_next_state u_next_state (
    .state_i         (state_q),
    .cmd_word_i      (in_data_q[15:0]),
    .fault_present_i (in_data_q[16]),
    .step_o          (step)
  );

  // Status of the new state
  dpps_status u_status (
    .state_i               (step.next_state),
    .warning_flag_i        (in_data_q[17]),
    .target_reached_flag_i (in_data_q[18]),
    .stall_flag_i          (in_data_q[19]),
    .stat_word_o           (stat_word),
    .op_enabled_o          (op_enabled),
    .faulted_o             (faulted)
  );

  // Counter updates and result packing
  assign trans_cnt_d = trans_cnt_q + {30'd0, step.trans_inc};
  assign fault_cnt_d = fault_cnt_q + {31'd0, step.fault_inc};
  assign out_data_d  = {3'd0, fault_cnt_d, trans_cnt_d, faulted, op_enabled,
                        stat_word, step.next_state};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_NOT_READY;
      trans_cnt_q <= 32'd0;
      fault_cnt_q <= 32'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (proc) begin
        state_q     <= step.next_state;
        trans_cnt_q <= trans_cnt_d;
        fault_cnt_q <= fault_cnt_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
    end
    if (proc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `DPPS_ASSERT(a_state_moves_on_item, clk_i, rst_ni,
               (state_q != $past(state_q)) |-> $past(proc),
               "state changed without a transaction")
  `DPPS_ASSERT(a_fault_cnt_to_fault, clk_i, rst_ni,
               (fault_cnt_q != $past(fault_cnt_q)) |-> (state_q == ST_FAULT),
               "fault count rose outside fault state")
  `DPPS_ASSERT(a_trans_step_bounded, clk_i, rst_ni,
               (trans_cnt_q - $past(trans_cnt_q)) <= 32'd2,
               "transition count jumped by more than two")
  `DPPS_ASSERT(a_out_tracks_state, clk_i, rst_ni,
               $past(proc) |-> (out_data_q[2:0] == state_q),
               "result state differs from state register")
  `DPPS_ASSERT_ALWAYS(a_reset_empty, clk_i,
                      !rst_ni |=> (!in_valid_q && !out_valid_q),
                      "pipeline holds a transaction in reset")

endmodule

`default_nettype wire

FILE: tb/sv/tb_drive_profile_power_state_machine.sv
// Self-checking stream testbench for the drive power state machine.
module tb_drive_profile_power_state_machine;
  timeunit 1ns;
  timeprecision 1ps;

  import dpps_pkg::*;

  localparam int unsigned NUM_DIRECTED     = 24;
  localparam int unsigned RANDOM_PER_PHASE = 534;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned MAX_REPORTS      = 10;

  // One input transaction: command word in the low bits, flags above
  typedef struct packed {
    logic        stall;
    logic        target;
    logic        warn;
    logic        fault;
    logic [15:0] cw;
  } drive_cmd_t;

  // One output transaction, packed as on m_axis_tdata[84:0]
  typedef struct packed {
    logic [31:0]  fault_total;
    logic [31:0]  transition_total;
    logic         faulted;
    logic         op_enabled;
    logic [15:0]  stat_word;
    power_state_e drive_state;
  } drive_status_t;

  typedef struct packed {
    drive_cmd_t    cmd;
    logic          typed;
    drive_status_t exp;
  } directed_row_t;

  typedef enum logic [2:0] {
    K_SHUTDOWN, K_SWITCH_ON, K_ENABLE_OP, K_DISABLE_V, K_QUICK_STOP, K_FAULT_RESET
  } cmd_kind_e;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  // Predictor state, advanced on every accepted input transaction
  power_state_e  drive_state_q = ST_NOT_READY;
  logic [31:0]   transition_cnt = '0;
  logic [31:0]   fault_entry_cnt = '0;
  drive_status_t status_q[$];

  // Row currently offered by the driver
  logic          cur_typed = 1'b0;
  drive_status_t cur_expected = '0;

  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  int unsigned   cycle_count = 0;
  int unsigned   err_count = 0;
  int unsigned   checked_count = 0;
  int unsigned   state_seen [8];
  directed_row_t directed_rows [NUM_DIRECTED];

  drive_profile_power_state_machine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic cmd_match(logic [15:0] cw, logic [15:0] mask, logic [15:0] val);
    return (cw & mask) == val;
  endfunction

  // Advance the predicted drive state by one command word and build its status
  function automatic drive_status_t apply_command(input drive_cmd_t c);
    drive_status_t r;
    power_state_e  nxt;
    logic [15:0]   sw;
    nxt = drive_state_q;
    if (c.fault && drive_state_q != ST_FAULT && drive_state_q != ST_FAULT_REACT) begin
      // fault entry passes through fault reaction: two state changes
      nxt = ST_FAULT;
      transition_cnt = transition_cnt + 32'd2;
      fault_entry_cnt = fault_entry_cnt + 32'd1;
    end else begin
      case (drive_state_q)
        ST_NOT_READY: nxt = ST_SWITCH_DIS;
        ST_SWITCH_DIS: begin
          if (cmd_match(c.cw, MASK_SHUTDOWN, CMD_SHUTDOWN)) nxt = ST_READY;
        end
        ST_READY: begin
          if (cmd_match(c.cw, MASK_SWITCH, CMD_SWITCH_ON)) nxt = ST_SWITCHED_ON;
          else if (cmd_match(c.cw, MASK_DISABLE_V, CMD_DISABLE_V)) nxt = ST_SWITCH_DIS;
        end
        ST_SWITCHED_ON: begin
          if (cmd_match(c.cw, MASK_SWITCH, CMD_ENABLE_OP)) nxt = ST_OP_ENABLED;
          else if (cmd_match(c.cw, MASK_SHUTDOWN, CMD_SHUTDOWN)) nxt = ST_READY;
          else if (cmd_match(c.cw, MASK_DISABLE_V, CMD_DISABLE_V)) nxt = ST_SWITCH_DIS;
        end
        ST_OP_ENABLED: begin
          if (cmd_match(c.cw, MASK_SWITCH, CMD_DISABLE_OP)) nxt = ST_SWITCHED_ON;
          else if (cmd_match(c.cw, MASK_SHUTDOWN, CMD_SHUTDOWN)) nxt = ST_READY;
          else if (cmd_match(c.cw, MASK_DISABLE_V, CMD_DISABLE_V)) nxt = ST_SWITCH_DIS;
          else if (cmd_match(c.cw, MASK_QSTOP, CMD_QSTOP)) nxt = ST_QUICK_STOP;
        end
        ST_QUICK_STOP: begin
          // only disable voltage leaves quick stop
          if (cmd_match(c.cw, MASK_DISABLE_V, CMD_DISABLE_V)) nxt = ST_SWITCH_DIS;
        end
        ST_FAULT_REACT: nxt = ST_FAULT;
        default: begin
          // fault reset is honored only once the fault has cleared
          if (c.cw[FAULT_RESET_BIT] && !c.fault) nxt = ST_SWITCH_DIS;
        end
      endcase
      if (nxt != drive_state_q) transition_cnt = transition_cnt + 32'd1;
    end
    drive_state_q = nxt;

    case (nxt)
      ST_NOT_READY:   sw = 16'h0000;
      ST_SWITCH_DIS:  sw = 16'h0040;
      ST_READY:       sw = 16'h0021;
      ST_SWITCHED_ON: sw = 16'h0023;
      ST_OP_ENABLED:  sw = 16'h0027;
      ST_QUICK_STOP:  sw = 16'h0007;
      ST_FAULT_REACT: sw = 16'h000F;
      default:        sw = 16'h0008;
    endcase
    sw[SW_VOLTAGE_BIT] = (nxt >= ST_READY) && (nxt <= ST_QUICK_STOP);
    sw[SW_WARNING_BIT] = c.warn;
    sw[SW_TARGET_BIT]  = c.target;
    sw[SW_STALL_BIT]   = c.stall;

    r.drive_state      = nxt;
    r.stat_word        = sw;
    r.op_enabled       = (nxt == ST_OP_ENABLED);
    r.faulted          = (nxt == ST_FAULT) || (nxt == ST_FAULT_REACT);
    r.transition_total = transition_cnt;
    r.fault_total      = fault_entry_cnt;
    return r;
  endfunction

  // Directed row checked against the predictor; flg = {stall, target, warn, fault}
  function automatic directed_row_t pred_row(logic [15:0] cw, logic [3:0] flg);
    directed_row_t row;
    row.cmd   = {flg, cw};
    row.typed = 1'b0;
    row.exp   = '0;
    return row;
  endfunction

  // Directed row with the expected result written out by hand
  function automatic directed_row_t typed_row(logic [15:0] cw, logic [3:0] flg,
                                              power_state_e st, logic [15:0] sw,
                                              logic [31:0] tc, logic [31:0] fc);
    directed_row_t row;
    row.cmd                  = {flg, cw};
    row.typed                = 1'b1;
    row.exp.drive_state      = st;
    row.exp.stat_word        = sw;
    row.exp.op_enabled       = (st == ST_OP_ENABLED);
    row.exp.faulted          = (st == ST_FAULT) || (st == ST_FAULT_REACT);
    row.exp.transition_total = tc;
    row.exp.fault_total      = fc;
    return row;
  endfunction

  // Mostly commands on a legal edge out of the current state, some off-path and noise
  function automatic drive_cmd_t random_command();
    drive_cmd_t  c;
    cmd_kind_e   kind;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.cw = 16'($urandom);
    kind = cmd_kind_e'($urandom_range(0, 5));
    if (pick < 70) begin
      case (drive_state_q)
        ST_SWITCH_DIS:  kind = K_SHUTDOWN;
        ST_READY:       kind = K_SWITCH_ON;
        ST_SWITCHED_ON: kind = K_ENABLE_OP;
        ST_OP_ENABLED: begin
          case ($urandom_range(0, 3))
            0:       kind = K_SWITCH_ON;
            1:       kind = K_SHUTDOWN;
            2:       kind = K_DISABLE_V;
            default: kind = K_QUICK_STOP;
          endcase
        end
        ST_QUICK_STOP:  kind = K_DISABLE_V;
        ST_FAULT:       kind = K_FAULT_RESET;
        default: ;
      endcase
    end
    if (pick < 85) begin
      case (kind)
        K_SHUTDOWN:   c.cw = (c.cw & ~MASK_SHUTDOWN) | CMD_SHUTDOWN;
        K_SWITCH_ON:  c.cw = (c.cw & ~MASK_SWITCH) | CMD_SWITCH_ON;
        K_ENABLE_OP:  c.cw = (c.cw & ~MASK_SWITCH) | CMD_ENABLE_OP;
        K_DISABLE_V:  c.cw = (c.cw & ~MASK_DISABLE_V) | CMD_DISABLE_V;
        K_QUICK_STOP: c.cw = (c.cw & ~MASK_QSTOP) | CMD_QSTOP;
        default:      c.cw[FAULT_RESET_BIT] = 1'b1;
      endcase
    end
    // hold the fault more often in fault state so blocked resets occur
    c.fault  = $urandom_range(0, 99) < ((drive_state_q == ST_FAULT) ? 30 : 5);
    c.warn   = 1'($urandom_range(0, 1));
    c.target = 1'($urandom_range(0, 1));
    c.stall  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_command(input drive_cmd_t c, input logic typed,
                              input drive_status_t exp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - $bits(drive_cmd_t)){1'b0}}, c};
    cur_typed     = typed;
    cur_expected  = exp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp,
                             input logic [31:0] act);
    if (exp !== act) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 checked_count, name, exp, act);
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Monitor: predict on accepted inputs, compare accepted outputs
  always @(posedge clk_i) begin
    drive_status_t pred;
    drive_status_t got;
    drive_status_t exp;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending",
               cycle_count, status_q.size());
      $display("FAIL");
      $finish;
    end else if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = apply_command(drive_cmd_t'(s_axis_tdata[$bits(drive_cmd_t)-1:0]));
        status_q.push_back(cur_typed ? cur_expected : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = drive_status_t'(m_axis_tdata[$bits(drive_status_t)-1:0]);
        if (status_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result with nothing pending: %h", m_axis_tdata);
        end else begin
          exp = status_q.pop_front();
          check_field("drive_state", 32'(exp.drive_state), 32'(got.drive_state));
          check_field("stat_word", 32'(exp.stat_word), 32'(got.stat_word));
          check_field("op_enabled", 32'(exp.op_enabled), 32'(got.op_enabled));
          check_field("faulted", 32'(exp.faulted), 32'(got.faulted));
          check_field("transition_total", exp.transition_total, got.transition_total);
          check_field("fault_total", exp.fault_total, got.fault_total);
          state_seen[exp.drive_state]++;
          checked_count++;
        end
      end
    end
  end

  initial begin
    foreach (state_seen[i]) state_seen[i] = 0;

    // Walk most legal edges, off-path commands, fault entry and fault reset
    directed_rows[0]  = typed_row(16'h0000, 4'b0000, ST_SWITCH_DIS, 16'h0040, 32'd1, 32'd0);
    directed_rows[1]  = typed_row(16'hFFFF, 4'b1110, ST_SWITCH_DIS, 16'h1640, 32'd1, 32'd0);
    directed_rows[2]  = pred_row(16'h0006, 4'b0010);
    directed_rows[3]  = pred_row(16'h0000, 4'b0100);
    directed_rows[4]  = pred_row(16'h0006, 4'b1000);
    directed_rows[5]  = pred_row(16'h0007, 4'b0000);
    directed_rows[6]  = pred_row(16'h0006, 4'b0000);
    directed_rows[7]  = pred_row(16'h0007, 4'b0000);
    directed_rows[8]  = pred_row(16'h0000, 4'b0000);
    directed_rows[9]  = pred_row(16'h0006, 4'b0000);
    directed_rows[10] = pred_row(16'h0007, 4'b0000);
    directed_rows[11] = pred_row(16'h000F, 4'b1110);
    directed_rows[12] = pred_row(16'h0007, 4'b0000);
    directed_rows[13] = pred_row(16'h000F, 4'b0000);
    directed_rows[14] = pred_row(16'h0006, 4'b0000);
    directed_rows[15] = pred_row(16'h0007, 4'b0000);
    directed_rows[16] = pred_row(16'h000F, 4'b0000);
    directed_rows[17] = pred_row(16'h0002, 4'b0000);
    // command with no edge out of quick stop, and fault reset outside fault
    directed_rows[18] = pred_row(16'h0086, 4'b0000);
    directed_rows[19] = pred_row(16'h0000, 4'b0000);
    directed_rows[20] = typed_row(16'h0000, 4'b0001, ST_FAULT, 16'h0008, 32'd20, 32'd1);
    // fault reset while the fault is still present, then once it clears
    directed_rows[21] = pred_row(16'h0080, 4'b0001);
    directed_rows[22] = typed_row(16'hFFFF, 4'b0000, ST_SWITCH_DIS, 16'h0040, 32'd21, 32'd1);
    directed_rows[23] = typed_row(16'h0006, 4'b1111, ST_FAULT, 16'h1608, 32'd23, 32'd2);

    // Reset held, then released on a falling edge
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) begin
        tx_idle_pct = 31;
        rx_idle_pct = 61;
      end else if (ph == 1) begin
        tx_idle_pct = 61;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 0) begin
        foreach (directed_rows[i])
          send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].exp);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_command(random_command(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then watch for stray ones
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results across three idle profiles; %0d fault entries, %0d transitions",
             checked_count, fault_entry_cnt, transition_cnt);
    $display("Results per state 0..7: %0d %0d %0d %0d %0d %0d %0d %0d; errors %0d",
             state_seen[0], state_seen[1], state_seen[2], state_seen[3],
             state_seen[4], state_seen[5], state_seen[6], state_seen[7], err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/dpps_pkg.sv
design/dpps_next_state.sv
design/dpps_status.sv
design/drive_profile_power_state_machine.sv
tb/sv/tb_drive_profile_power_state_machine.sv
